[hdl/ep2d_pkg.sv]
// Shared types, constants and the month-length table for the epoch-to-date converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ep2d_pkg;

	localparam int EpochWidth = 32;
	localparam int YearWidth  = 12;
	localparam int MonthWidth = 4;
	localparam int DayWidth   = 5;
	localparam int DayBitIdxW = 3;

	localparam logic [EpochWidth-1:0] SecsPerDay     = 32'd86400;
	localparam logic [EpochWidth-1:0] SecsLeapYear   = 32'd31622400;
	localparam logic [EpochWidth-1:0] SecsCommonYear = 32'd31536000;

	localparam logic [YearWidth-1:0]  FirstYear     = 12'd1970;
	localparam logic [YearWidth-1:0]  LastYear      = 12'd4095;
	localparam logic [1:0]            FirstMod4     = 2'd2;
	localparam logic [6:0]            FirstMod100   = 7'd70;
	localparam logic [8:0]            FirstMod400   = 9'd370;
	localparam logic [6:0]            LastMod100    = 7'd99;
	localparam logic [8:0]            LastMod400    = 9'd399;
	localparam logic [MonthWidth-1:0] LastMonthIdx  = 4'd11;
	localparam logic [MonthWidth-1:0] FebIdx        = 4'd1;
	localparam logic [DayBitIdxW-1:0] TopDayBit     = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step_year;
		logic step_month;
		logic step_day;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic year_last;
		logic month_last;
		logic day_last;
	} dp_sts_t;

	// Length in seconds of the month with zero-based index m.
	function automatic logic [EpochWidth-1:0] month_secs(input logic [MonthWidth-1:0] m,
			input logic leap);
		logic [4:0] days;
		days = 5'd31;
		unique case (m)
			FebIdx:  days = leap ? 5'd29 : 5'd28;
			4'd3,
			4'd5,
			4'd8,
			4'd10:   days = 5'd30;
			default: days = 5'd31;
		endcase
		return 32'(days) * SecsPerDay;
	endfunction

endpackage

`default_nettype wire

[hdl/epoch_seconds_to_date.sv]
// Top level of the epoch-to-date converter: controller plus datapath.
// Depends on ep2d_pkg, ep2d_ctrl and ep2d_dp.
//
// Usage: drive epoch_seconds and raise start while busy is low; the item is
// taken at that clock edge and busy rises on the next cycle. The block then
// strips whole years from the count one per cycle, whole months one per cycle,
// and finds the day number as a five-bit quotient by 86400, one bit per cycle.
// When the date is ready, done is high for exactly one cycle and year, month
// and day_of_month hold the result from that cycle on until the next item is loaded. The receiver cannot
// stall the block, so the result must be captured in that cycle.
// The controller passes through the year loop, the month loop, the day bits
// and a done state; busy falls with the end of the done cycle and a new item
// may be accepted in the next one. The year loop, one subtraction of a year
// length per cycle, sets the worst-case conversion time.
// Only one item is in flight at a time. Reset returns the controller to idle
// at once; the datapath registers need no reset and are loaded with each item.
`default_nettype none

module epoch_seconds_to_date import ep2d_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [EpochWidth-1:0] epoch_seconds,
	output logic                       busy,
	output logic                       done,
	output logic [YearWidth-1:0]       year,
	output logic [MonthWidth-1:0]      month,
	output logic [DayWidth-1:0]        day_of_month
);

	// Command and status bundles between the two halves.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller sequences load, year steps, month steps and day bits.
	ep2d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the remaining seconds and the partial date.
	ep2d_dp u_dp (
		.clk           (clk),
		.epoch_seconds (epoch_seconds),
		.cmd           (cmd),
		.sts           (sts),
		.year          (year),
		.month         (month),
		.day_of_month  (day_of_month)
	);

endmodule

`default_nettype wire

[hdl/ep2d_dp.sv]
// Datapath of the epoch-to-date converter: remainder, year, month and day registers.
// Depends on ep2d_pkg.
`default_nettype none

module ep2d_dp import ep2d_pkg::*; (
	input  wire logic                  clk,
	input  wire logic [EpochWidth-1:0] epoch_seconds,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts,
	output logic [YearWidth-1:0]       year,
	output logic [MonthWidth-1:0]      month,
	output logic [DayWidth-1:0]        day_of_month
);

	logic [EpochWidth-1:0] rem_q;
	logic [YearWidth-1:0]  year_q;
	logic [1:0]            mod4_q;
	logic [6:0]            mod100_q;
	logic [8:0]            mod400_q;
	logic [MonthWidth-1:0] month_q;
	logic [DayWidth-1:0]   day_q;
	logic [DayBitIdxW-1:0] dbit_q;

	logic                  leap;
	logic [EpochWidth-1:0] ylen;
	logic [EpochWidth-1:0] mlen;
	logic [EpochWidth-1:0] dchunk;
	logic                  dfit;

	// Leap rule from the running residues of the year.
	assign leap   = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
	assign ylen   = leap ? SecsLeapYear : SecsCommonYear;
	assign mlen   = month_secs(month_q, leap);
	assign dchunk = SecsPerDay << dbit_q;
	assign dfit   = rem_q >= dchunk;

	assign sts.year_last  = (rem_q < ylen) || (year_q == LastYear);
	assign sts.month_last = (rem_q < mlen) || (month_q == LastMonthIdx);
	assign sts.day_last   = (dbit_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q    <= epoch_seconds;
			year_q   <= FirstYear;
			mod4_q   <= FirstMod4;
			mod100_q <= FirstMod100;
			mod400_q <= FirstMod400;
			month_q  <= '0;
			day_q    <= '0;
			dbit_q   <= TopDayBit;
		end else if (cmd.step_year) begin
			rem_q    <= rem_q - ylen;
			year_q   <= year_q + 12'd1;
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == LastMod100) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == LastMod400) ? 9'd0 : mod400_q + 9'd1;
		end else if (cmd.step_month) begin
			rem_q   <= rem_q - mlen;
			month_q <= month_q + 4'd1;
		end else if (cmd.step_day) begin
			// One quotient bit of the day count per cycle, most significant first.
			if (dfit) begin
				rem_q <= rem_q - dchunk;
			end
			day_q[dbit_q] <= dfit;
			dbit_q        <= dbit_q - 3'd1;
		end
	end

	assign year         = year_q;
	assign month        = month_q + 4'd1;
	assign day_of_month = day_q + 5'd1;

endmodule

`default_nettype wire

[hdl/ep2d_ctrl.sv]
// Controller state machine of the epoch-to-date converter.
// Depends on ep2d_pkg.
`default_nettype none

module ep2d_ctrl import ep2d_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         busy,
	output logic         done
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_YEAR  = 5'b00010,
		ST_MONTH = 5'b00100,
		ST_DAY   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_YEAR;
				end
			end
			ST_YEAR: begin
				if (sts.year_last) begin
					state_d = ST_MONTH;
				end else begin
					cmd.step_year = 1'b1;
				end
			end
			ST_MONTH: begin
				if (sts.month_last) begin
					state_d = ST_DAY;
				end else begin
					cmd.step_month = 1'b1;
				end
			end
			ST_DAY: begin
				cmd.step_day = 1'b1;
				if (sts.day_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

`default_nettype wire

[hdl/ep2d_checker.sv]
// Port-level checks for the epoch-to-date converter, bound to the top level.
// Depends on ep2d_pkg and epoch_seconds_to_date.
`default_nettype none

module ep2d_checker import ep2d_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic [YearWidth-1:0]  year,
	input wire logic [MonthWidth-1:0] month,
	input wire logic [DayWidth-1:0]   day_of_month
);

	// An accepted item makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block did not go busy after an accepted item");

	// The result strobe comes only while busy and ends the work on the item.
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy && !done)
		else $error("result strobe outside a conversion or not single-cycle");

	// Busy never rises without an accepted item.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("block went busy without a start");

	// A delivered date lies in the range reachable from a 32-bit count.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (year >= 12'd1970) && (year <= 12'd2106) && (month >= 4'd1)
			&& (month <= 4'd12) && (day_of_month >= 5'd1))
		else $error("delivered date out of range");

endmodule

bind epoch_seconds_to_date ep2d_checker u_ep2d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.year         (year),
	.month        (month),
	.day_of_month (day_of_month)
);

`default_nettype wire
